// ===== hw/rtl/tkm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tkm_pkg;

  localparam int MaxK    = 16;
  localparam int ScoreW  = 18;
  localparam int TagW    = 16;
  localparam int CommonW = 12;
  localparam int SlotW   = 4;
  localparam int KW      = 5;

  localparam logic [KW-1:0] KReset = KW'(1);

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncRead   = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StCmp,
    StUpd,
    StRead
  } tkm_state_e;

  typedef struct packed {
    logic latch;
    logic compare;
    logic update;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic rd_last;
  } dp_status_t;

  // Absolute value of a two's complement score. The most negative code maps to
  // its true magnitude, which still fits the unsigned width.
  function automatic logic [ScoreW-1:0] mag_f(logic signed [ScoreW-1:0] s);
    logic [ScoreW-1:0] u;
    u = s;
    return s[ScoreW-1] ? (~u + ScoreW'(1)) : u;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tkm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tkm_in_if;
  import tkm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [ScoreW-1:0]  score;
  logic        [TagW-1:0]    item_tag;
  logic        [CommonW-1:0] common_count;

  modport source (
    output valid, func, score, item_tag, common_count,
    input  ready
  );

  modport sink (
    input  valid, func, score, item_tag, common_count,
    output ready
  );

endinterface

`default_nettype wire

// ===== hw/rtl/tkm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tkm_out_if;
  import tkm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [SlotW-1:0]   slot;
  logic signed [ScoreW-1:0]  score_out;
  logic        [TagW-1:0]    tag_out;
  logic        [CommonW-1:0] common_out;
  logic                      is_empty;
  logic                      last;

  modport source (
    output valid, slot, score_out, tag_out, common_out, is_empty, last,
    input  ready
  );

  modport sink (
    input  valid, slot, score_out, tag_out, common_out, is_empty, last,
    output ready
  );

endinterface

`default_nettype wire

// ===== hw/rtl/tkm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkm_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_func_i,
  output logic                        in_ready_o,
  input  wire tkm_pkg::dp_status_t    status_i,
  output tkm_pkg::ctrl_cmd_t          cmd_o
);
  import tkm_pkg::*;

  tkm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = (in_func_i == FuncRead) ? StRead : StCmp;
        end
      end
      StCmp: begin
        state_d = StUpd;
      end
      StUpd: begin
        state_d = StIdle;
      end
      StRead: begin
        if (status_i.out_free && status_i.rd_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      StCmp: begin
        cmd_o.compare = 1'b1;
      end
      StUpd: begin
        cmd_o.update = 1'b1;
      end
      StRead: begin
        cmd_o.load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> status_i.out_free)
    else $error("Result loaded while the output register is occupied.");

  a_cmp_then_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCmp |=> state_q == StUpd)
    else $error("Compare step not followed by the update step.");

  a_insert_compares: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_func_i == FuncInsert) |=> cmd_o.compare)
    else $error("Accepted insert did not start a compare.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tkm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkm_dp #(
  parameter int MAX_K = tkm_pkg::MaxK
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic        [tkm_pkg::KW-1:0]       cfg_wdata_i,
  input  wire logic signed [tkm_pkg::ScoreW-1:0]   in_score_i,
  input  wire logic        [tkm_pkg::TagW-1:0]     in_tag_i,
  input  wire logic        [tkm_pkg::CommonW-1:0]  in_common_i,
  input  wire tkm_pkg::ctrl_cmd_t                  cmd_i,
  output tkm_pkg::dp_status_t                      status_o,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic             [tkm_pkg::SlotW-1:0]    out_slot_o,
  output logic signed      [tkm_pkg::ScoreW-1:0]   out_score_o,
  output logic             [tkm_pkg::TagW-1:0]     out_tag_o,
  output logic             [tkm_pkg::CommonW-1:0]  out_common_o,
  output logic                                     out_is_empty_o,
  output logic                                     out_last_o
);
  import tkm_pkg::*;

  localparam int FW = $clog2(MAX_K + 1);
  localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW = (FW > KW) ? FW : KW;

  logic signed [ScoreW-1:0]  ent_score_q  [MAX_K];
  logic        [TagW-1:0]    ent_tag_q    [MAX_K];
  logic        [CommonW-1:0] ent_common_q [MAX_K];
  logic signed [ScoreW-1:0]  ent_score_d  [MAX_K];
  logic        [TagW-1:0]    ent_tag_d    [MAX_K];
  logic        [CommonW-1:0] ent_common_d [MAX_K];

  logic [FW-1:0] fill_q, fill_d;
  logic [KW-1:0] k_q;
  logic [CW-1:0] k_eff;

  logic signed [ScoreW-1:0]  cand_score_q;
  logic        [TagW-1:0]    cand_tag_q;
  logic        [CommonW-1:0] cand_common_q;
  logic        [ScoreW-1:0]  cand_mag_q;

  logic [MAX_K-1:0] valid_v;
  logic [MAX_K-1:0] ge_d, ge_q;
  logic             front_d, front_q;
  logic [MAX_K-1:0] keep;
  logic [MAX_K-1:0] cand_at;
  logic             lt_any, is_empty, is_append, is_middle, full_k, at_max, upd_we;

  logic [IW-1:0] rd_idx_q;
  logic          rd_last;

  logic                      out_valid_q;
  logic [SlotW-1:0]          out_slot_q;
  logic signed [ScoreW-1:0]  out_score_q;
  logic [TagW-1:0]           out_tag_q;
  logic [CommonW-1:0]        out_common_q;
  logic                      out_is_empty_q;
  logic                      out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= KReset;
    end else if (cfg_we_i) begin
      k_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (k_q == '0) begin
      k_eff = CW'(1);
    end else if (CW'(k_q) > CW'(MAX_K)) begin
      k_eff = CW'(MAX_K);
    end else begin
      k_eff = CW'(k_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cand_score_q  <= in_score_i;
      cand_tag_q    <= in_tag_i;
      cand_common_q <= in_common_i;
      cand_mag_q    <= mag_f(in_score_i);
    end
  end

  // Every stored slot is compared with the candidate at once; the list is
  // sorted, so the slots at or above the candidate form a prefix.
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      valid_v[i] = FW'(i) < fill_q;
      ge_d[i]    = valid_v[i] && (mag_f(ent_score_q[i]) >= cand_mag_q);
    end
    front_d = cand_mag_q >= mag_f(ent_score_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      ge_q    <= ge_d;
      front_q <= front_d;
    end
  end

  always_comb begin
    lt_any    = |(valid_v & ~ge_q);
    is_empty  = fill_q == '0;
    is_append = !is_empty && !lt_any;
    is_middle = !is_empty && lt_any && !front_q;
    full_k    = CW'(fill_q) >= k_eff;
    at_max    = fill_q == FW'(MAX_K);
    upd_we    = !(is_append && full_k);

    for (int i = 0; i < MAX_K; i++) begin
      keep[i] = ge_q[i] && !(front_q && lt_any);
    end
    cand_at[0] = !keep[0];
    for (int i = 1; i < MAX_K; i++) begin
      cand_at[i] = !keep[i] && keep[i-1];
    end

    ent_score_d[0]  = cand_at[0] ? cand_score_q  : ent_score_q[0];
    ent_tag_d[0]    = cand_at[0] ? cand_tag_q    : ent_tag_q[0];
    ent_common_d[0] = cand_at[0] ? cand_common_q : ent_common_q[0];
    for (int i = 1; i < MAX_K; i++) begin
      if (keep[i]) begin
        ent_score_d[i]  = ent_score_q[i];
        ent_tag_d[i]    = ent_tag_q[i];
        ent_common_d[i] = ent_common_q[i];
      end else if (cand_at[i]) begin
        ent_score_d[i]  = cand_score_q;
        ent_tag_d[i]    = cand_tag_q;
        ent_common_d[i] = cand_common_q;
      end else begin
        ent_score_d[i]  = ent_score_q[i-1];
        ent_tag_d[i]    = ent_tag_q[i-1];
        ent_common_d[i] = ent_common_q[i-1];
      end
    end

    // A middle insert into a list filled to the full depth shortens the list
    // by one when k is below that depth.
    if (is_middle && at_max && (k_eff < CW'(MAX_K))) begin
      fill_d = fill_q - FW'(1);
    end else if (full_k) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && upd_we) begin
      ent_score_q  <= ent_score_d;
      ent_tag_q    <= ent_tag_d;
      ent_common_q <= ent_common_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.update) begin
      fill_q <= fill_d;
    end
  end

  assign rd_last = is_empty || ((FW'(rd_idx_q) + FW'(1)) == fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.latch) begin
      rd_idx_q <= '0;
    end else if (cmd_i.load) begin
      rd_idx_q <= rd_idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_is_empty_q <= is_empty;
      out_last_q     <= rd_last;
      if (is_empty) begin
        out_slot_q   <= '0;
        out_score_q  <= '0;
        out_tag_q    <= '0;
        out_common_q <= '0;
      end else begin
        out_slot_q   <= SlotW'(rd_idx_q);
        out_score_q  <= ent_score_q[rd_idx_q];
        out_tag_q    <= ent_tag_q[rd_idx_q];
        out_common_q <= ent_common_q[rd_idx_q];
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.rd_last  = rd_last;

  assign out_valid_o    = out_valid_q;
  assign out_slot_o     = out_slot_q;
  assign out_score_o    = out_score_q;
  assign out_tag_o      = out_tag_q;
  assign out_common_o   = out_common_q;
  assign out_is_empty_o = out_is_empty_q;
  assign out_last_o     = out_last_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_K))
    else $error("Fill count exceeds the list depth.");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> fill_q <= $past(fill_q) + 1)
    else $error("Fill count grew by more than one on an insert.");

  a_fill_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.update |=> $stable(fill_q))
    else $error("Fill count changed outside an insert.");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_is_empty_q) |-> out_last_q)
    else $error("Empty marker not flagged as the final result.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/top_k_by_magnitude_list.sv =====
// Best candidates sorted by score magnitude, up to k (more if k is lowered).
// The in_i channel takes one item per transfer: func selects an insert of a
// candidate (score, item_tag, common_count) or a read-out of the whole list.
// The out_o channel carries one transfer per stored entry, slot 0 first, with
// last set on the final one; a read-out of an empty list gives a single
// transfer with is_empty and last set and all other fields zero.
// An insert produces no result and occupies the block for the accept, a
// compare step in which all slots are compared with the candidate in
// parallel, and an update step in which the list shifts and the fill updates.
// A read-out moves from the accept to the read state, which loads the results
// into the output register one result per cycle while out_o does not stall.
// The results pass through a single output register; while out_o stalls,
// that register holds its transfer and the read-out waits. The next item is
// accepted as soon as the last result is in the output register.
// cfg_we_i writes k from cfg_wdata_i and must only be used while idle.
// Reset empties the list and sets k to 1; stored entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module top_k_by_magnitude_list #(
  parameter int MAX_K = tkm_pkg::MaxK
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [tkm_pkg::KW-1:0]  cfg_wdata_i,
  tkm_in_if.sink                       in_i,
  tkm_out_if.source                    out_o
);
  import tkm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  tkm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tkm_dp #(
    .MAX_K (MAX_K)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_score_i     (in_i.score),
    .in_tag_i       (in_i.item_tag),
    .in_common_i    (in_i.common_count),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_slot_o     (out_o.slot),
    .out_score_o    (out_o.score_out),
    .out_tag_o      (out_o.tag_out),
    .out_common_o   (out_o.common_out),
    .out_is_empty_o (out_o.is_empty),
    .out_last_o     (out_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

// ===== tb/sv/top_k_by_magnitude_list_test.sv =====
`timescale 1ns / 1ps

module top_k_by_magnitude_list_test;
  import tkm_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned LongHold   = 200;

  typedef struct packed {
    logic [ScoreW-1:0]  score;
    logic [TagW-1:0]    tag;
    logic [CommonW-1:0] common;
  } cand_t;

  typedef struct packed {
    logic  func;
    cand_t cand;
  } job_t;

  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic [ScoreW-1:0]  score;
    logic [TagW-1:0]    tag;
    logic [CommonW-1:0] common;
    logic               is_empty;
    logic               last;
  } row_t;

  logic          clk_i;
  logic          rst_ni = 1'b1;
  logic          cfg_we_i = 1'b0;
  logic [KW-1:0] cfg_wdata_i = '0;

  tkm_in_if  in_ch ();
  tkm_out_if out_ch ();

  top_k_by_magnitude_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  job_t              queued_jobs[$];
  row_t              awaited_rows[$];
  logic [ScoreW-1:0] recent_scores[$];

  cand_t             ranked[MaxK];
  int unsigned       ranked_fill = 0;
  logic [KW-1:0]     k_setting = KReset;

  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       gap_left;
  int unsigned       next_gap;
  int unsigned       stall_left;
  int unsigned       next_stall;
  logic              sent_now;
  logic              in_gaps_on = 1'b1;
  logic              out_stalls_on = 1'b1;
  logic              want_long_hold = 1'b0;
  logic              long_hold_done;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [ScoreW-1:0] score_size(logic [ScoreW-1:0] s);
    if (s[ScoreW-1]) begin
      return ScoreW'(0) - s;
    end
    return s;
  endfunction

  function automatic int unsigned k_limit();
    if (k_setting == 0) begin
      return 1;
    end
    if (k_setting > MaxK) begin
      return MaxK;
    end
    return k_setting;
  endfunction

  function automatic void slide_in(int unsigned pos, cand_t c);
    for (int unsigned i = ranked_fill; i > pos; i--) begin
      ranked[i] = ranked[i - 1];
    end
    ranked[pos] = c;
    ranked_fill++;
  endfunction

  function automatic void add_candidate(cand_t c);
    int unsigned       lim;
    int unsigned       pos;
    logic [ScoreW-1:0] size;
    lim = k_limit();
    size = score_size(c.score);
    if (ranked_fill == 0) begin
      slide_in(0, c);
    end else if (size <= score_size(ranked[ranked_fill - 1].score)) begin
      if (ranked_fill < lim) begin
        slide_in(ranked_fill, c);
      end
    end else if (size >= score_size(ranked[0].score)) begin
      if (ranked_fill >= lim) begin
        ranked_fill--;
      end
      slide_in(0, c);
    end else begin
      pos = 1;
      while (pos < ranked_fill && score_size(ranked[pos].score) >= size) begin
        pos++;
      end
      if (ranked_fill >= MaxK) begin
        ranked_fill--;
        if (pos > ranked_fill) begin
          return;
        end
      end
      slide_in(pos, c);
      if (ranked_fill > lim) begin
        ranked_fill--;
      end
    end
  endfunction

  function automatic void expect_readout();
    row_t r;
    r = '0;
    if (ranked_fill == 0) begin
      r.is_empty = 1'b1;
      r.last = 1'b1;
      awaited_rows.insert(awaited_rows.size(), r);
      return;
    end
    for (int unsigned i = 0; i < ranked_fill; i++) begin
      r.slot = SlotW'(i);
      r.score = ranked[i].score;
      r.tag = ranked[i].tag;
      r.common = ranked[i].common;
      r.is_empty = 1'b0;
      r.last = (i + 1 == ranked_fill);
      awaited_rows.insert(awaited_rows.size(), r);
    end
  endfunction

  function automatic void apply_job(job_t j);
    if (j.func == FuncInsert) begin
      add_candidate(j.cand);
    end else begin
      expect_readout();
    end
  endfunction

  function automatic void check_row(row_t got);
    row_t want;
    if (awaited_rows.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("unexpected transfer: slot %0d score %0d tag %h common %0d empty %b last %b",
                 got.slot, $signed(got.score), got.tag, got.common, got.is_empty, got.last);
      end
      return;
    end
    want = awaited_rows.pop_front();
    if (got.slot !== want.slot || got.score !== want.score || got.tag !== want.tag ||
        got.common !== want.common || got.is_empty !== want.is_empty ||
        got.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch: expected slot %0d score %0d tag %h common %0d empty %b last %b",
                 want.slot, $signed(want.score), want.tag, want.common, want.is_empty,
                 want.last);
        $display("          actual   slot %0d score %0d tag %h common %0d empty %b last %b",
                 got.slot, $signed(got.score), got.tag, got.common, got.is_empty, got.last);
      end
    end
  endfunction

  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end
    if (pick < 87) begin
      return $urandom_range(1, 3);
    end
    if (pick < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ScoreW-1:0] draw_score(int unsigned band);
    logic [ScoreW-1:0] s;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      s = ScoreW'($urandom);
    end else if (pick < 35 && recent_scores.size() > 0) begin
      s = recent_scores[$urandom_range(0, recent_scores.size() - 1)];
    end else if (pick < 42) begin
      s = ScoreW'($urandom_range(0, 40));
    end else begin
      s = ScoreW'(band * 6000 + $urandom_range(0, 20000));
    end
    if ($urandom_range(0, 1) == 1) begin
      s = ScoreW'(0) - s;
    end
    recent_scores.insert(recent_scores.size(), s);
    if (recent_scores.size() > 24) begin
      void'(recent_scores.pop_front());
    end
    return s;
  endfunction

  task automatic offer_insert(int score, int tag, int common);
    job_t j;
    j.func = FuncInsert;
    j.cand.score = ScoreW'(score);
    j.cand.tag = TagW'(tag);
    j.cand.common = CommonW'(common);
    queued_jobs.insert(queued_jobs.size(), j);
  endtask

  task automatic offer_readout();
    job_t j;
    j.func = FuncRead;
    j.cand.score = ScoreW'($urandom);
    j.cand.tag = TagW'($urandom);
    j.cand.common = CommonW'($urandom);
    queued_jobs.insert(queued_jobs.size(), j);
  endtask

  task automatic queue_mix(int unsigned count, int unsigned band, int unsigned read_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < read_pct) begin
        offer_readout();
      end else begin
        offer_insert(int'(draw_score(band)), int'($urandom_range(0, 65535)),
                     int'($urandom_range(0, 4095)));
      end
    end
  endtask

  task automatic settle();
    while (queued_jobs.size() != 0 || awaited_rows.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_k(int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= KW'(value);
    k_setting = KW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= FuncInsert;
      in_ch.score <= '0;
      in_ch.item_tag <= '0;
      in_ch.common_count <= '0;
      gap_left <= 0;
    end else begin
      sent_now = in_ch.valid && in_ch.ready;
      if (sent_now) begin
        apply_job(queued_jobs.pop_front());
        next_gap = in_gaps_on ? idle_length() : 0;
      end else begin
        next_gap = gap_left;
      end
      if (!in_ch.valid || sent_now) begin
        if (next_gap > 0) begin
          in_ch.valid <= 1'b0;
          gap_left <= next_gap - 1;
        end else if (queued_jobs.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.func <= queued_jobs[0].func;
          in_ch.score <= queued_jobs[0].cand.score;
          in_ch.item_tag <= queued_jobs[0].cand.tag;
          in_ch.common_count <= queued_jobs[0].cand.common;
          gap_left <= 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_row({out_ch.slot, out_ch.score_out, out_ch.tag_out, out_ch.common_out,
                   out_ch.is_empty, out_ch.last});
      end
      if (want_long_hold && !long_hold_done) begin
        out_ch.ready <= 1'b0;
        stall_left <= LongHold;
        long_hold_done <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        next_stall = out_stalls_on ? idle_length() : 0;
        if (next_stall > 0) begin
          out_ch.ready <= 1'b0;
          stall_left <= next_stall - 1;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k_plan[8];
    k_plan = '{16, 0, 31, 17, 7, 1, 12, 3};
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_k(4);
    offer_readout();
    offer_insert(0, 16'h0000, 12'h000);
    offer_insert(131071, 16'hFFFF, 12'hFFF);
    offer_insert(-131072, 16'h0001, 12'h001);
    offer_insert(-131071, 16'h0002, 12'h002);
    offer_insert(0, 16'h0003, 12'h003);
    offer_readout();
    offer_insert(65536, 16'hA5A5, 12'h5A5);
    offer_insert(-65536, 16'h5A5A, 12'hA5A);
    offer_insert(-1, 16'h0004, 12'h004);
    offer_readout();
    settle();

    write_k(16);
    offer_insert(-65536, 16'h0005, 12'h005);
    offer_insert(1, 16'h0006, 12'h006);
    offer_insert(-1, 16'h0007, 12'h007);
    offer_insert(131071, 16'h0008, 12'h008);
    offer_readout();
    settle();

    // The list now holds more entries than the lowered setting allows.
    write_k(2);
    offer_insert(5, 16'h0009, 12'h009);
    offer_insert(-131072, 16'h000A, 12'h00A);
    offer_insert(70000, 16'h000B, 12'h00B);
    offer_readout();
    settle();

    for (int p = 0; p < 8; p++) begin
      write_k(k_plan[p]);
      in_gaps_on = (p % 3 != 1);
      out_stalls_on = (p % 3 != 2);
      queue_mix(30, p, 15);
      settle();
    end

    write_k(16);
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    want_long_hold = 1'b1;
    queue_mix(20, 7, 50);
    settle();

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
